// ===== rtl/ptbg_pkg.sv =====
`timescale 1ns / 1ps
package ptbg_pkg;

  localparam int unsigned MaxLayers    = 4;
  localparam int unsigned NumLayersDef = 4;
  localparam int unsigned LayerW       = 38;
  localparam int unsigned StrengthW    = 14;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned LayerAw      = $clog2(MaxLayers);
  localparam int unsigned PaddrW       = LayerAw + 3;
  localparam int unsigned PdataW       = 64;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 24;
  localparam int unsigned GammaDepth   = 1 << ChanW;

  localparam logic [StrengthW-1:0] GrayLimit = 14'd10000;

  localparam logic OpTint  = 1'b0;
  localparam logic OpGamma = 1'b1;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [LayerW-1:0] layer_t;

  typedef struct packed {
    logic  op;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t gamma_index;
    chan_t gamma_value;
  } word_t;

  function automatic chan_t blend_chan(chan_t ch, chan_t target,
                                       logic [StrengthW-1:0] strength);
    logic signed [ChanW+1:0]           diff;
    logic signed [StrengthW+ChanW+2:0] prod;
    logic signed [StrengthW+ChanW+2:0] delta;
    logic signed [StrengthW+ChanW+2:0] sum;
    diff  = $signed({2'b00, target}) - $signed({2'b00, ch});
    prod  = $signed({1'b0, strength}) * diff;
    delta = prod >>> ChanW;
    sum   = $signed({{(StrengthW+3){1'b0}}, ch}) + delta;
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({{(StrengthW+3){1'b0}}, {ChanW{1'b1}}})) begin
      return {ChanW{1'b1}};
    end else begin
      return sum[ChanW-1:0];
    end
  endfunction

  function automatic chan_t gray_chan(chan_t r, chan_t g, chan_t b);
    logic [16:0] acc;
    acc = 17'(r) * 17'd76 + 17'(g) * 17'd141 + 17'(b) * 17'd38;
    return acc[15:8];
  endfunction

endpackage

// ===== rtl/ptbg_tint_cell.sv =====
`timescale 1ns / 1ps
module ptbg_tint_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ptbg_pkg::layer_t layer_i,
  input  logic           valid_i,
  input  ptbg_pkg::word_t word_i,
  output logic           valid_o,
  output ptbg_pkg::word_t word_o
);
  import ptbg_pkg::*;

  logic                 valid_q;
  word_t                word_q, word_d;
  logic [StrengthW-1:0] strength;
  chan_t                gray;

  assign strength = layer_i[LayerW-1:3*ChanW];
  assign gray     = gray_chan(word_i.red, word_i.green, word_i.blue);

  always_comb begin
    word_d = word_i;
    if (strength > GrayLimit) begin
      word_d.red   = gray;
      word_d.green = gray;
      word_d.blue  = gray;
    end else begin
      word_d.red   = blend_chan(word_i.red,   layer_i[ChanW-1:0],         strength);
      word_d.green = blend_chan(word_i.green, layer_i[2*ChanW-1:ChanW],   strength);
      word_d.blue  = blend_chan(word_i.blue,  layer_i[3*ChanW-1:2*ChanW], strength);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/ptbg_gamma_lut.sv =====
`timescale 1ns / 1ps
module ptbg_gamma_lut (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ptbg_pkg::word_t word_i,
  output logic            valid_o,
  output ptbg_pkg::chan_t red_o,
  output ptbg_pkg::chan_t green_o,
  output ptbg_pkg::chan_t blue_o
);
  import ptbg_pkg::*;

  chan_t                 mem_r [GammaDepth];
  chan_t                 mem_g [GammaDepth];
  chan_t                 mem_b [GammaDepth];
  logic [GammaDepth-1:0] written_q;
  logic                  valid_q;
  logic                  wr;
  chan_t                 rd_r_q, rd_g_q, rd_b_q;
  chan_t                 idx_r_q, idx_g_q, idx_b_q;
  logic                  hit_r_q, hit_g_q, hit_b_q;

  assign wr = en_i && valid_i && (word_i.op == OpGamma);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_r[word_i.gamma_index] <= word_i.gamma_value;
      mem_g[word_i.gamma_index] <= word_i.gamma_value;
      mem_b[word_i.gamma_index] <= word_i.gamma_value;
    end
    if (en_i) begin
      rd_r_q  <= mem_r[word_i.red];
      rd_g_q  <= mem_g[word_i.green];
      rd_b_q  <= mem_b[word_i.blue];
      idx_r_q <= word_i.red;
      idx_g_q <= word_i.green;
      idx_b_q <= word_i.blue;
      hit_r_q <= written_q[word_i.red];
      hit_g_q <= written_q[word_i.green];
      hit_b_q <= written_q[word_i.blue];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr) begin
        written_q[word_i.gamma_index] <= 1'b1;
      end
      if (en_i) begin
        valid_q <= valid_i && (word_i.op == OpTint);
      end
    end
  end

  assign valid_o = valid_q;
  assign red_o   = hit_r_q ? rd_r_q : idx_r_q;
  assign green_o = hit_g_q ? rd_g_q : idx_g_q;
  assign blue_o  = hit_b_q ? rd_b_q : idx_b_q;

endmodule

// ===== rtl/palette_tint_blend_gamma.sv =====
`timescale 1ns / 1ps
// Palette tint, blend and gamma mapping.
// Slave stream: one word per color (tuser = 0) or per gamma table write (tuser = 1).
// Master stream: one word per color: the tinted, gamma-mapped RGB triple.
// Gamma writes produce no output word and take effect for every later color.
// Tint layers are 38-bit registers on the APB port at byte address 8*i:
// bits 7:0 red, 15:8 green, 23:16 blue, 37:24 strength.
// Each layer is one cell of a pipeline chain; a word moves one cell per cycle
// while the chain is not stalled, then through the registered gamma table read.
// Throughput: one word per cycle while the receiver does not stall, set by the
// registered cells and the one-read-per-channel gamma table port.
// Reset clears the layer registers to zero, empties the pipeline and makes the
// gamma table read as identity until entries are written.
// When the receiver stalls with a word pending, the whole chain holds and
// s_axis_tready drops; bubbles in the chain hold in place as well.
module palette_tint_blend_gamma #(
  parameter int unsigned NUM_LAYERS = ptbg_pkg::NumLayersDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptbg_pkg::PaddrW-1:0] paddr,
  input  logic [ptbg_pkg::PdataW-1:0] pwdata,
  output logic [ptbg_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // in_red, in_green, in_blue, gamma_index, gamma_value
  input  logic [ptbg_pkg::InDataW-1:0] s_axis_tdata,
  // op
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_red, out_green, out_blue
  output logic [ptbg_pkg::OutDataW-1:0] m_axis_tdata
);
  import ptbg_pkg::*;

  layer_t             layer_q [MaxLayers];
  logic [LayerAw-1:0] widx;
  logic               en;
  logic               valid_c [NUM_LAYERS+1];
  word_t              word_c  [NUM_LAYERS+1];
  chan_t              out_r, out_g, out_b;

  assign pready = 1'b1;
  assign widx   = paddr[PaddrW-1:3];
  assign prdata = {{(PdataW-LayerW){1'b0}}, layer_q[widx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLayers; i++) begin
        layer_q[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      layer_q[widx] <= pwdata[LayerW-1:0];
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign valid_c[0]             = s_axis_tvalid;
  assign word_c[0].op           = s_axis_tuser;
  assign word_c[0].red          = s_axis_tdata[7:0];
  assign word_c[0].green        = s_axis_tdata[15:8];
  assign word_c[0].blue         = s_axis_tdata[23:16];
  assign word_c[0].gamma_index  = s_axis_tdata[31:24];
  assign word_c[0].gamma_value  = s_axis_tdata[39:32];

  for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_cell
    ptbg_tint_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .layer_i (layer_q[g]),
      .valid_i (valid_c[g]),
      .word_i  (word_c[g]),
      .valid_o (valid_c[g+1]),
      .word_o  (word_c[g+1])
    );
  end

  ptbg_gamma_lut u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[NUM_LAYERS]),
    .word_i  (word_c[NUM_LAYERS]),
    .valid_o (m_axis_tvalid),
    .red_o   (out_r),
    .green_o (out_g),
    .blue_o  (out_b)
  );

  assign m_axis_tdata = {out_b, out_g, out_r};

endmodule
